// ----- rtl/smu_pkg.sv -----
// Shared definitions for the SGD momentum update block: field widths,
// configuration register indexes, reset values and Q16.16 helper functions.
// No dependencies.
package smu_pkg;

  localparam int IDX_W    = 12;
  localparam int DATA_W   = 32;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = DATA_W + COEF_W + 1;
  localparam int TERM_W   = PROD_W - COEF_W;
  localparam int SUM_W    = DATA_W + 2;
  localparam int CFG_IDX_W = 2;

  localparam int DEFAULT_VEL_DEPTH = 4096;

  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY      = 2'd2;

  localparam logic [COEF_W-1:0] LEARN_RATE_RST = 16'd655;
  localparam logic [COEF_W-1:0] MOMENTUM_RST   = 16'd0;
  localparam logic [COEF_W-1:0] DECAY_RST      = 16'd0;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  // Exact product of an unsigned Q0.16 factor and a signed Q16.16 value.
  function automatic logic signed [PROD_W-1:0] mul_coef(input logic [COEF_W-1:0] coef,
                                                          input logic signed [DATA_W-1:0] x);
    logic signed [PROD_W-1:0] c;
    logic signed [PROD_W-1:0] v;
    c = PROD_W'($signed({1'b0, coef}));
    v = PROD_W'(x);
    return PROD_W'(c * v);
  endfunction

  // Round half toward plus infinity back to Q16.16.
  function automatic logic signed [TERM_W-1:0] rnd_q16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + PROD_W'(32768);
    return s[PROD_W-1:COEF_W];
  endfunction

  function automatic logic [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [DATA_W-1:0] r;
    if ((v[SUM_W-1:DATA_W-1] == '0) || (v[SUM_W-1:DATA_W-1] == '1)) begin
      r = v[DATA_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = SAT_MIN;
    end else begin
      r = SAT_MAX;
    end
    return r;
  endfunction

endpackage

// ----- rtl/smu_vel_store.sv -----
// Velocity store: a synchronous memory with one read and one write port,
// a zeroing sweep after reset and forwarding of the latest write.
// Depends on smu_pkg.
module smu_vel_store
  import smu_pkg::*;
#(
  parameter int DEPTH = DEFAULT_VEL_DEPTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic              busy
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_q_r;
  logic [AW-1:0]     rd_addr_r;
  logic              clr_busy_r;
  logic [AW-1:0]     clr_addr_r;
  logic              last_v_r;
  logic [AW-1:0]     last_addr_r;
  logic [DATA_W-1:0] last_data_r;

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r   <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // The most recent write holds the current contents of its entry, so a
  // match on it is always safe to return in place of the array output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_v_r <= 1'b0;
    end else if (wr_en && !clr_busy_r) begin
      last_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !clr_busy_r) begin
      last_addr_r <= wr_addr;
      last_data_r <= wr_data;
    end
  end

  assign rd_data = (last_v_r && (last_addr_r == rd_addr_r)) ? last_data_r : mem_q_r;
  assign busy    = clr_busy_r;

endmodule

// ----- rtl/sgd_momentum_update.sv -----
// SGD with momentum and weight decay, one parameter element per transaction.
// Depends on smu_pkg and smu_vel_store.
//
// Channel  Dir  Payload (low bit first)                        End / flag
// in_      in   elem_index, param_value, grad_value            tlast step_end, tuser grad_present
// out_     out  new_param, decayed_grad                        none
// cfg_     in   learn_rate, momentum_factor, decay_factor      write only
//
// One transaction per cycle while no output stall, hazard or store clearing holds the input.
// An element is held back while an older one with the same in-store index, a gradient and
// momentum on has not yet reached write-back in the multiply-then-add velocity loop around the
// store's read port. After reset the store is zeroed, one entry a cycle, with in_tready low.
// Each stage holds its item only while the stage after it is full and stalled, so bubbles
// close up under output backpressure.
module sgd_momentum_update
  import smu_pkg::*;
#(
  parameter int VEL_DEPTH = DEFAULT_VEL_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [79:0]          in_tdata,   // elem_index, param_value, grad_value, zero pad
  input  logic                 in_tlast,
  input  logic [0:0]           in_tuser,   // grad_present
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [63:0]          out_tdata,  // new_param, decayed_grad
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_wdata
);

  localparam int AW    = (VEL_DEPTH > 1) ? $clog2(VEL_DEPTH) : 1;
  localparam int CMP_W = ((AW > IDX_W) ? AW : IDX_W) + 1;

  logic [COEF_W-1:0] learn_rate_r;
  logic [COEF_W-1:0] momentum_r;
  logic [COEF_W-1:0] decay_r;
  logic              first_pass_r;
  logic              first_pass_nxt;

  logic [IDX_W-1:0]  in_idx;
  logic [DATA_W-1:0] in_param;
  logic [DATA_W-1:0] in_grad;
  logic              in_fire;
  logic              in_inside;
  logic [CMP_W-1:0]  in_idx_ext;
  logic              hazard;

  logic en_out, en4, en3, en2, en1;

  // Stage 1: read data arrives, decay term is added, momentum product formed.
  logic                     s1_v_r;
  logic [IDX_W-1:0]         s1_idx_r;
  logic [DATA_W-1:0]        s1_param_r;
  logic [DATA_W-1:0]        s1_grad_r;
  logic                     s1_present_r;
  logic                     s1_first_r;
  logic                     s1_inside_r;
  logic                     s1_wen_r;
  logic                     s1_mom_on_r;
  logic signed [PROD_W-1:0] s1_dprod_r;
  logic [DATA_W-1:0]        s1_dgrad;
  logic [DATA_W-1:0]        s1_vel_old;
  logic signed [SUM_W-1:0]  s1_dsum;

  // Stage 2: velocity update and write-back.
  logic                     s2_v_r;
  logic [IDX_W-1:0]         s2_idx_r;
  logic [DATA_W-1:0]        s2_param_r;
  logic                     s2_present_r;
  logic                     s2_first_r;
  logic                     s2_wen_r;
  logic                     s2_mom_on_r;
  logic [DATA_W-1:0]        s2_dgrad_r;
  logic signed [PROD_W-1:0] s2_mprod_r;
  logic signed [SUM_W-1:0]  s2_vsum;
  logic [DATA_W-1:0]        s2_vel_new;
  logic [DATA_W-1:0]        s2_step;
  logic [CMP_W-1:0]         s2_idx_ext;
  logic                     vel_wr;

  // Stage 3: step value registered for the learning rate product.
  logic              s3_v_r;
  logic [DATA_W-1:0] s3_param_r;
  logic              s3_present_r;
  logic [DATA_W-1:0] s3_dgrad_r;
  logic [DATA_W-1:0] s3_step_r;

  // Stage 4: subtraction from the parameter.
  logic                     s4_v_r;
  logic [DATA_W-1:0]        s4_param_r;
  logic                     s4_present_r;
  logic [DATA_W-1:0]        s4_dgrad_r;
  logic signed [PROD_W-1:0] s4_lprod_r;
  logic signed [SUM_W-1:0]  s4_psum;

  logic              out_v_r;
  logic [DATA_W-1:0] out_param_r;
  logic [DATA_W-1:0] out_dgrad_r;

  logic              vel_busy;
  logic [DATA_W-1:0] vel_rd_data;

  assign in_idx   = in_tdata[IDX_W-1:0];
  assign in_param = in_tdata[IDX_W+DATA_W-1:IDX_W];
  assign in_grad  = in_tdata[IDX_W+2*DATA_W-1:IDX_W+DATA_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_rate_r <= LEARN_RATE_RST;
      momentum_r   <= MOMENTUM_RST;
      decay_r      <= DECAY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LEARN_RATE: learn_rate_r <= cfg_wdata;
        CFG_MOMENTUM:   momentum_r   <= cfg_wdata;
        CFG_DECAY:      decay_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en_out = !out_v_r || out_tready;
  assign en4    = !s4_v_r || en_out;
  assign en3    = !s3_v_r || en4;
  assign en2    = !s2_v_r || en3;
  assign en1    = !s1_v_r || en2;

  assign in_idx_ext = CMP_W'(in_idx);
  assign in_inside  = in_idx_ext < CMP_W'(VEL_DEPTH);

  // An element must not read its velocity before an older update of the same
  // entry has been written or is being written at this edge.
  assign hazard = (s1_v_r && s1_wen_r && (s1_idx_r == in_idx)) ||
                  (s2_v_r && s2_wen_r && !en3 && (s2_idx_r == in_idx));

  assign in_tready = !vel_busy && en1 && !hazard;
  assign in_fire   = in_tvalid && in_tready;

  assign first_pass_nxt = (in_fire && in_tlast) ? 1'b0 : first_pass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_pass_r <= 1'b1;
    end else begin
      first_pass_r <= first_pass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_fire) begin
      s1_idx_r     <= in_idx;
      s1_param_r   <= in_param;
      s1_grad_r    <= in_grad;
      s1_present_r <= in_tuser[0];
      s1_first_r   <= first_pass_r;
      s1_inside_r  <= in_inside;
      s1_mom_on_r  <= momentum_r != '0;
      s1_wen_r     <= in_tuser[0] && in_inside && (momentum_r != '0);
      s1_dprod_r   <= mul_coef(decay_r, in_param);
    end
  end

  smu_vel_store #(
    .DEPTH (VEL_DEPTH),
    .AW    (AW)
  ) u_vel_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (in_idx_ext[AW-1:0]),
    .rd_data (vel_rd_data),
    .wr_en   (vel_wr),
    .wr_addr (s2_idx_ext[AW-1:0]),
    .wr_data (s2_vel_new),
    .busy    (vel_busy)
  );

  assign s1_dsum    = SUM_W'($signed(s1_grad_r)) + SUM_W'(rnd_q16(s1_dprod_r));
  assign s1_dgrad   = sat32(s1_dsum);
  assign s1_vel_old = s1_inside_r ? vel_rd_data : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_v_r) begin
      s2_idx_r     <= s1_idx_r;
      s2_param_r   <= s1_param_r;
      s2_present_r <= s1_present_r;
      s2_first_r   <= s1_first_r;
      s2_wen_r     <= s1_wen_r;
      s2_mom_on_r  <= s1_mom_on_r;
      s2_dgrad_r   <= s1_dgrad;
      s2_mprod_r   <= mul_coef(momentum_r, s1_vel_old);
    end
  end

  assign s2_vsum    = SUM_W'(rnd_q16(s2_mprod_r)) + SUM_W'($signed(s2_dgrad_r));
  assign s2_vel_new = s2_first_r ? s2_dgrad_r : sat32(s2_vsum);
  assign s2_step    = s2_mom_on_r ? s2_vel_new : s2_dgrad_r;
  assign s2_idx_ext = CMP_W'(s2_idx_r);
  assign vel_wr     = s2_v_r && s2_wen_r && en3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && s2_v_r) begin
      s3_param_r   <= s2_param_r;
      s3_present_r <= s2_present_r;
      s3_dgrad_r   <= s2_dgrad_r;
      s3_step_r    <= s2_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en4) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && s3_v_r) begin
      s4_param_r   <= s3_param_r;
      s4_present_r <= s3_present_r;
      s4_dgrad_r   <= s3_dgrad_r;
      s4_lprod_r   <= mul_coef(learn_rate_r, s3_step_r);
    end
  end

  assign s4_psum = SUM_W'($signed(s4_param_r)) - SUM_W'(rnd_q16(s4_lprod_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en_out) begin
      out_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && s4_v_r) begin
      out_param_r <= s4_present_r ? sat32(s4_psum) : s4_param_r;
      out_dgrad_r <= s4_present_r ? s4_dgrad_r : '0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_dgrad_r, out_param_r};

  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) vel_busy |-> !in_fire
  ) else $error("input accepted during velocity store clearing");

  a_no_overlapping_update: assert property (
    @(posedge clk) disable iff (!rst_n)
    (s1_v_r && s2_v_r && s1_wen_r && s2_wen_r) |-> (s1_idx_r != s2_idx_r)
  ) else $error("two velocity updates of one entry overlap");

  a_stalled_stage_blocks_input: assert property (
    @(posedge clk) disable iff (!rst_n) (s1_v_r && !en2) |-> !in_tready
  ) else $error("input accepted while stage one is held");

  a_write_only_with_momentum: assert property (
    @(posedge clk) disable iff (!rst_n) vel_wr |-> (momentum_r != '0)
  ) else $error("velocity written with momentum disabled");

endmodule

// ----- tb/sgd_momentum_update_test.sv -----
// Self-checking testbench for sgd_momentum_update: streams parameter elements under
// random idling on both channels and checks each result against a local predictor.
// Depends on smu_pkg and the sgd_momentum_update RTL.
`timescale 1ns / 1ps

module sgd_momentum_update_test;
  import smu_pkg::*;

  localparam int STORE_DEPTH = DEFAULT_VEL_DEPTH;
  localparam int STALL_LIMIT = 4 * STORE_DEPTH + 4000;
  localparam int RANDOM_PER_PHASE = 117;
  localparam int NUM_PHASES = 6;

  typedef struct {
    logic [IDX_W-1:0]         elem_index;
    logic signed [DATA_W-1:0] param_value;
    logic signed [DATA_W-1:0] grad_value;
    logic                     grad_present;
    logic                     step_end;
  } elem_t;

  typedef struct {
    logic [DATA_W-1:0] new_param;
    logic [DATA_W-1:0] decayed_grad;
  } update_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [79:0]          in_tdata = '0;
  logic                 in_tlast = 1'b0;
  logic [0:0]           in_tuser = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [63:0]          out_tdata;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_wdata = '0;

  elem_t   pending_elems[$];
  update_t expected_updates[$];
  elem_t   cur_elem;
  update_t want;

  int   vel_mem [STORE_DEPTH];
  bit   first_step = 1'b1;
  logic [COEF_W-1:0] lr_coef = LEARN_RATE_RST;
  logic [COEF_W-1:0] momentum_coef = MOMENTUM_RST;
  logic [COEF_W-1:0] decay_coef = DECAY_RST;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  sgd_momentum_update #(
    .VEL_DEPTH(STORE_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint scale_q16(input logic [COEF_W-1:0] coef, input longint x);
    longint c;
    c = longint'(coef);
    return (c * x + 32768) >>> 16;
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic update_t apply_update(input elem_t e);
    update_t r;
    longint  p;
    longint  dg;
    longint  v;
    longint  np;
    bit      in_store;
    p = e.param_value;
    np = p;
    dg = 0;
    if (e.grad_present) begin
      dg = e.grad_value;
      if (decay_coef != 0) dg = clip32(dg + scale_q16(decay_coef, p));
      if (momentum_coef != 0) begin
        in_store = e.elem_index < STORE_DEPTH;
        v = in_store ? longint'(vel_mem[e.elem_index]) : 0;
        if (first_step) v = dg;
        else v = clip32(scale_q16(momentum_coef, v) + dg);
        if (in_store) vel_mem[e.elem_index] = int'(v);
        np = clip32(p - scale_q16(lr_coef, v));
      end else begin
        np = clip32(p - scale_q16(lr_coef, dg));
      end
    end
    if (e.step_end) first_step = 1'b0;
    r.new_param = np[31:0];
    r.decayed_grad = dg[31:0];
    return r;
  endfunction

  function automatic elem_t make_elem(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] p,
                                      input logic [DATA_W-1:0] g, input logic present,
                                      input logic last);
    elem_t e;
    e.elem_index = idx;
    e.param_value = p;
    e.grad_value = g;
    e.grad_present = present;
    e.step_end = last;
    return e;
  endfunction

  function automatic logic [DATA_W-1:0] random_value();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0: return SAT_MAX;
          1: return SAT_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: return $urandom();
      default: return $urandom_range(32'h003f_ffff) - 32'h0020_0000;
    endcase
  endfunction

  function automatic elem_t random_elem();
    logic [IDX_W-1:0] idx;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: idx = IDX_W'($urandom_range(7));
      6, 7: idx = IDX_W'($urandom_range(4095, STORE_DEPTH - 4));
      default: idx = IDX_W'($urandom());
    endcase
    return make_elem(idx, random_value(), random_value(), $urandom_range(99) < 85,
                     $urandom_range(99) < 4);
  endfunction

  task automatic queue_elem(input elem_t e);
    pending_elems = {pending_elems, e};
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_LEARN_RATE: lr_coef = val;
      CFG_MOMENTUM: momentum_coef = val;
      CFG_DECAY: decay_coef = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_elems.size() != 0 || in_tvalid || expected_updates.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_updates = {expected_updates, apply_update(cur_elem)};
      end
      if (!in_tvalid || in_tready) begin
        if (pending_elems.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_elem = pending_elems.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {4'b0, cur_elem.grad_value, cur_elem.param_value, cur_elem.elem_index};
          in_tlast <= cur_elem.step_end;
          in_tuser <= cur_elem.grad_present;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_tvalid && out_tready) begin
        if (expected_updates.size() == 0) begin
          $error("unexpected result transaction: %h", out_tdata);
          mismatches++;
        end else begin
          want = expected_updates.pop_front();
          if (out_tdata[31:0] !== want.new_param) begin
            $error("new_param: expected %h, actual %h", want.new_param, out_tdata[31:0]);
            mismatches++;
          end
          if (out_tdata[63:32] !== want.decayed_grad) begin
            $error("decayed_grad: expected %h, actual %h", want.decayed_grad, out_tdata[63:32]);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (pending_elems.size() == 0 && !in_tvalid && expected_updates.size() == 0)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    logic [COEF_W-1:0] lr_set [NUM_PHASES];
    logic [COEF_W-1:0] mom_set [NUM_PHASES];
    logic [COEF_W-1:0] dec_set [NUM_PHASES];
    lr_set = '{16'hffff, 16'd655, 16'h0, 16'h0, 16'h0, 16'h4000};
    mom_set = '{16'hffff, 16'h0, 16'he666, 16'h8000, 16'h0, 16'h0001};
    dec_set = '{16'hffff, 16'h0, 16'h0, 16'hffff, 16'h0, 16'h0100};
    lr_set[2] = COEF_W'($urandom_range(65535));
    lr_set[4] = COEF_W'($urandom_range(65535));
    mom_set[4] = COEF_W'($urandom_range(65535, 1));
    dec_set[4] = COEF_W'($urandom_range(65535));
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct = (ph < 2) ? 30 : (ph < 4) ? 74 : 0;
      recv_idle_pct = (ph < 2) ? 74 : (ph < 4) ? 30 : 0;
      write_reg(CFG_LEARN_RATE, lr_set[ph]);
      write_reg(CFG_MOMENTUM, mom_set[ph]);
      write_reg(CFG_DECAY, dec_set[ph]);
      if (ph == 0) begin
        // First optimizer step: velocity takes the decayed gradient directly.
        queue_elem(make_elem(IDX_W'(0), SAT_MAX, SAT_MAX, 1'b1, 1'b0));
        queue_elem(make_elem(IDX_W'(1), SAT_MIN, SAT_MIN, 1'b1, 1'b0));
        queue_elem(make_elem(IDX_W'(2), SAT_MAX, SAT_MIN, 1'b1, 1'b0));
        queue_elem(make_elem(IDX_W'(3), SAT_MIN, SAT_MAX, 1'b1, 1'b0));
        queue_elem(make_elem(IDX_W'(4095), 32'h0001_0000, 32'h0000_8000, 1'b1, 1'b0));
        queue_elem(make_elem(IDX_W'(STORE_DEPTH - 1), '1, 32'd1, 1'b1, 1'b0));
        queue_elem(make_elem(IDX_W'(5), 32'h1234_5678, 32'hdead_beef, 1'b0, 1'b0));
        queue_elem(make_elem(IDX_W'(6), '0, '0, 1'b1, 1'b0));
        queue_elem(make_elem(IDX_W'(7), 32'd1, '1, 1'b1, 1'b0));
        queue_elem(make_elem(IDX_W'(0), 32'h0002_0000, 32'hffff_0000, 1'b1, 1'b0));
        queue_elem(make_elem(IDX_W'(8), 32'h7654_3210, 32'h0123_4567, 1'b0, 1'b1));
        // Later steps: momentum term, back-to-back hits on one entry.
        queue_elem(make_elem(IDX_W'(0), 32'h0001_0000, 32'h0000_4000, 1'b1, 1'b0));
        queue_elem(make_elem(IDX_W'(0), 32'hfff0_0000, 32'h0003_0000, 1'b1, 1'b0));
        queue_elem(make_elem(IDX_W'(0), 32'h0000_0001, 32'hffff_ffff, 1'b1, 1'b0));
        queue_elem(make_elem(IDX_W'(1), SAT_MAX, SAT_MIN, 1'b1, 1'b0));
        queue_elem(make_elem(IDX_W'(4095), 32'h0010_0000, 32'h0000_1000, 1'b1, 1'b0));
        queue_elem(make_elem(IDX_W'(STORE_DEPTH - 1), '1, 32'd1, 1'b1, 1'b0));
        queue_elem(make_elem(IDX_W'(2), 32'h0000_8000, 32'h0000_8000, 1'b1, 1'b1));
      end
      repeat (RANDOM_PER_PHASE) queue_elem(random_elem());
      wait_idle();
    end
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
